// File: rtl/mcg_pkg.sv
// Types, constants and small lookup functions for the month calendar grid block.
// Used by every module in rtl/; no dependencies.
package mcg_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COL_W    = 3;
    localparam int YSH_W    = 15;   // year shifted by one 400-year cycle
    localparam int SUM_W    = 15;   // day-of-week sum before mod 7

    localparam int QUEUE_DEPTH_DEF = 2;

    // floor(x/100) = (x * RECIP_100) >> SH_100, exact for x < 43690
    localparam int RECIP_100 = 5243;
    localparam int SH_100    = 19;
    // floor(x/7) = (x * RECIP_7) >> SH_7, exact for x < 43690
    localparam int RECIP_7   = 37450;
    localparam int SH_7      = 18;

    localparam logic [COL_W-1:0] LAST_COL = 3'd6;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
    } req_t;

    typedef struct packed {
        logic [DAY_W-1:0] day_number;
        logic [COL_W-1:0] weekday_column;
        logic             row_end;
        logic [COL_W-1:0] first_offset;
        logic             bad_request;
        logic             last;
    } res_t;

    // one classified request, handed from front to back
    typedef struct packed {
        logic             bad;
        logic [DAY_W-1:0] len;
        logic [COL_W-1:0] start;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_DIV,
        FR_SUM,
        FR_MOD,
        FR_PUSH
    } front_state_t;

    // month length for a common year; month assumed 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo);
        logic [DAY_W-1:0] d;
        case (mo)
            4'd2:    d = 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    // floor(31*m/12) for the March-based month index m = 1..12
    function automatic logic [DAY_W-1:0] month_shift(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] v;
        case (m)
            4'd1:    v = 5'd2;
            4'd2:    v = 5'd5;
            4'd3:    v = 5'd7;
            4'd4:    v = 5'd10;
            4'd5:    v = 5'd12;
            4'd6:    v = 5'd15;
            4'd7:    v = 5'd18;
            4'd8:    v = 5'd20;
            4'd9:    v = 5'd23;
            4'd10:   v = 5'd25;
            4'd11:   v = 5'd28;
            4'd12:   v = 5'd31;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/mcg_front.sv
// Front end: accepts a year/month request, checks the month, computes month length
// and weekday of day one in DIV, SUM, MOD states, pushes a job. Depends on mcg_pkg.
module mcg_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mcg_pkg::req_t        s_data,
    input  logic                 q_full,
    output mcg_pkg::push_t       q_push
);

    mcg_pkg::front_state_t state_reg, state_next;

    logic [mcg_pkg::YEAR_W-1:0]  yr_reg;
    logic [mcg_pkg::YSH_W-1:0]   y_reg;
    logic [mcg_pkg::MONTH_W-1:0] m_reg;
    logic [mcg_pkg::DAY_W-1:0]   len_reg;
    logic                        feb_reg;
    logic                        bad_reg;
    logic [7:0]                  q100_y_reg;
    logic [7:0]                  q100_yr_reg;
    logic [mcg_pkg::SUM_W-1:0]   sum_reg;
    logic [12:0]                 q7_reg;
    logic                        leap_reg;

    logic [27:0]                 prod_y, prod_yr;
    logic [30:0]                 prod_7;
    logic [mcg_pkg::YEAR_W-1:0]  r100;
    logic [mcg_pkg::SUM_W-1:0]   sum_next;
    logic                        leap_next;
    logic                        jan_feb;
    logic                        accept;
    logic [mcg_pkg::SUM_W-1:0]   rem7;
    logic [mcg_pkg::DAY_W-1:0]   len_out;

    assign s_ready = (state_reg == mcg_pkg::FR_IDLE);
    assign accept  = s_valid && s_ready;
    assign jan_feb = (s_data.month <= 4'd2);

    assign prod_y  = 28'(y_reg) * 28'(mcg_pkg::RECIP_100);
    assign prod_yr = 28'(yr_reg) * 28'(mcg_pkg::RECIP_100);
    assign prod_7  = 31'(sum_reg) * 31'(mcg_pkg::RECIP_7);

    assign r100 = yr_reg - 14'(q100_yr_reg * 14'd100);
    // divisible by 100: leap only if the century count is a multiple of 4
    assign leap_next = (r100 == '0) ? (q100_yr_reg[1:0] == 2'b00) : (yr_reg[1:0] == 2'b00);

    assign sum_next = 15'd1 + y_reg + (y_reg >> 2) - 15'(q100_y_reg) + 15'(q100_y_reg >> 2)
                    + 15'(mcg_pkg::month_shift(m_reg));

    assign rem7    = sum_reg - 15'(q7_reg * 13'd7);
    assign len_out = (feb_reg && leap_reg) ? 5'd29 : len_reg;

    always_comb begin
        state_next    = state_reg;
        q_push.push   = 1'b0;
        q_push.job.bad   = bad_reg;
        q_push.job.len   = bad_reg ? '0 : len_out;
        q_push.job.start = bad_reg ? '0 : rem7[mcg_pkg::COL_W-1:0];
        case (state_reg)
            mcg_pkg::FR_IDLE: begin
                if (accept) begin
                    if (s_data.month == 4'd0 || s_data.month > 4'd12) begin
                        state_next = mcg_pkg::FR_PUSH;
                    end else begin
                        state_next = mcg_pkg::FR_DIV;
                    end
                end
            end
            mcg_pkg::FR_DIV: state_next = mcg_pkg::FR_SUM;
            mcg_pkg::FR_SUM: state_next = mcg_pkg::FR_MOD;
            mcg_pkg::FR_MOD: state_next = mcg_pkg::FR_PUSH;
            mcg_pkg::FR_PUSH: begin
                if (!q_full) begin
                    q_push.push = 1'b1;
                    state_next  = mcg_pkg::FR_IDLE;
                end
            end
            default: state_next = mcg_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcg_pkg::FR_IDLE;
            bad_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                bad_reg <= (s_data.month == 4'd0 || s_data.month > 4'd12);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            yr_reg  <= s_data.year;
            y_reg   <= 15'(s_data.year) + 15'd400 - 15'(jan_feb);
            m_reg   <= jan_feb ? (s_data.month + 4'd10) : (s_data.month - 4'd2);
            len_reg <= mcg_pkg::month_days(s_data.month);
            feb_reg <= (s_data.month == 4'd2);
        end
        if (state_reg == mcg_pkg::FR_DIV) begin
            q100_y_reg  <= prod_y[mcg_pkg::SH_100 +: 8];
            q100_yr_reg <= prod_yr[mcg_pkg::SH_100 +: 8];
        end
        if (state_reg == mcg_pkg::FR_SUM) begin
            sum_reg  <= sum_next;
            leap_reg <= leap_next;
        end
        if (state_reg == mcg_pkg::FR_MOD) begin
            q7_reg <= prod_7[mcg_pkg::SH_7 +: 13];
        end
    end

    a_push_only_in_push: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.push |-> (state_reg == mcg_pkg::FR_PUSH && !q_full))
        else $error("front pushed outside push state or into full queue");

    a_start_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.push |-> (q_push.job.start <= mcg_pkg::LAST_COL))
        else $error("weekday of day one out of range");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push.push && !q_push.job.bad) |->
            (q_push.job.len >= 5'd28 && q_push.job.len <= 5'd31))
        else $error("month length out of range");

endmodule

// File: rtl/mcg_queue.sv
// Short job queue between front end and emitter.
// Depends on mcg_pkg.
module mcg_queue #(
    parameter int DEPTH = mcg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  mcg_pkg::push_t q_push,
    output logic           q_full,
    input  logic           q_pop,
    output logic           q_empty,
    output mcg_pkg::job_t  q_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mcg_pkg::job_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     do_push, do_pop;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop) count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= q_push.job;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.push |-> !q_full)
        else $error("push into full queue");

endmodule

// File: rtl/mcg_back.sv
// Emitter: takes a job from the queue and sends one day cell per cycle
// through a registered output while m_ready allows. Depends on mcg_pkg.
module mcg_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  mcg_pkg::job_t q_head,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output mcg_pkg::res_t m_data
);

    logic                      active_reg;
    mcg_pkg::job_t             job_reg;
    logic [mcg_pkg::DAY_W-1:0] day_reg;
    logic [mcg_pkg::COL_W-1:0] col_reg;
    logic                      m_valid_reg;
    mcg_pkg::res_t             m_data_reg;

    logic                      advance;
    logic                      cell_last;
    mcg_pkg::res_t             day_cell;

    assign advance   = !m_valid_reg || m_ready;
    assign q_pop     = !active_reg && !q_empty;
    assign cell_last = job_reg.bad || (day_reg == job_reg.len);

    always_comb begin
        if (job_reg.bad) begin
            day_cell = '0;
            day_cell.bad_request = 1'b1;
            day_cell.last        = 1'b1;
        end else begin
            day_cell.day_number     = day_reg;
            day_cell.weekday_column = col_reg;
            day_cell.row_end        = (col_reg == mcg_pkg::LAST_COL);
            day_cell.first_offset   = job_reg.start;
            day_cell.bad_request    = 1'b0;
            day_cell.last           = cell_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (active_reg && advance) begin
                m_valid_reg <= 1'b1;
                if (cell_last) active_reg <= 1'b0;
            end else begin
                if (advance) m_valid_reg <= 1'b0;
                if (q_pop) active_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (active_reg && advance) begin
            m_data_reg <= day_cell;
            day_reg    <= day_reg + 5'd1;
            col_reg    <= (col_reg == mcg_pkg::LAST_COL) ? '0 : col_reg + 3'd1;
        end else if (q_pop) begin
            job_reg <= q_head;
            day_reg <= 5'd1;
            col_reg <= q_head.start;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.weekday_column <= mcg_pkg::LAST_COL))
        else $error("weekday column out of range");

    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bad_request) |-> (m_data.last && m_data.day_number == '0))
        else $error("error cell not a lone last cell");

    a_day_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !job_reg.bad) |-> (day_reg >= 5'd1 && day_reg <= job_reg.len))
        else $error("day counter past month length");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !active_reg)
        else $error("job taken while emitting");

endmodule

// File: rtl/month_calendar_grid_generator_core.sv
// Month calendar grid generator: one request in, one cell per day of the month out,
// one error cell for a bad month. A request passes the front states DIV, SUM, MOD
// and PUSH (only PUSH for a bad month), the job queue and the output register. The
// front end (multiply-based divide steps) takes no new request until it has pushed
// its job; the emitter sends one cell per cycle while m_ready allows, one job at a
// time. Synchronous active-low reset empties all.
module month_calendar_grid_generator_core #(
    parameter int QUEUE_DEPTH = mcg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mcg_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mcg_pkg::res_t m_data
);

    mcg_pkg::push_t q_push;
    mcg_pkg::job_t  q_head;
    logic           q_full, q_empty, q_pop;

    mcg_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push)
    );

    mcg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    mcg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: sim/mcg_checker.sv
// Scoreboard for the month calendar grid block: watches both channels, predicts
// the day cells of every accepted request and compares them in order.
// Depends on rtl/mcg_pkg.sv for the request and cell types.
module mcg_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  mcg_pkg::req_t s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  mcg_pkg::res_t m_data,
    output int            errors,
    output int            pending,
    output int            cells_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DAY_BITS = mcg_pkg::DAY_W;
    localparam int COL_BITS = mcg_pkg::COL_W;
    localparam int unsigned COMMON_DAYS [1:12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned WEEK = 7;
    localparam int unsigned REPORT_MAX = 10;

    mcg_pkg::res_t cells_due[$];

    // calendar state as the block would hold it after each request
    logic [DAY_BITS-1:0] cur_day;
    logic [COL_BITS-1:0] next_col;
    logic [DAY_BITS-1:0] cur_len;
    logic [COL_BITS-1:0] cur_start;

    function automatic bit is_leap(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    endfunction

    task automatic add_month_cells(input mcg_pkg::req_t req);
        int unsigned yr;
        int unsigned mo;
        int unsigned jan_feb;
        int unsigned ys;
        int unsigned ms;
        int unsigned len;
        int unsigned start;
        int unsigned col;
        mcg_pkg::res_t day_cell;
        yr = req.year;
        mo = req.month;
        if (mo < 1 || mo > 12) begin
            day_cell = '0;
            day_cell.bad_request = 1'b1;
            day_cell.last = 1'b1;
            cells_due.push_back(day_cell);
            cur_day = '0;
            next_col = '0;
            cur_len = '0;
            cur_start = '0;
            return;
        end
        // March-based year; +400 keeps year 0 from going negative
        jan_feb = (14 - mo) / 12;
        ys = yr + 400 - jan_feb;
        ms = mo + 12 * jan_feb - 2;
        start = (1 + ys + ys / 4 - ys / 100 + ys / 400 + (31 * ms) / 12) % WEEK;
        len = (mo == 2) ? (is_leap(yr) ? 29 : 28) : COMMON_DAYS[mo];
        col = start;
        for (int unsigned d = 1; d <= len; d++) begin
            day_cell = '0;
            day_cell.day_number = DAY_BITS'(d);
            day_cell.weekday_column = COL_BITS'(col);
            day_cell.row_end = (col == WEEK - 1);
            day_cell.first_offset = COL_BITS'(start);
            day_cell.last = (d == len);
            cells_due.push_back(day_cell);
            col = (col == WEEK - 1) ? 0 : col + 1;
        end
        cur_day = DAY_BITS'(len);
        next_col = COL_BITS'(col);
        cur_len = DAY_BITS'(len);
        cur_start = COL_BITS'(start);
    endtask

    always @(posedge aclk) begin
        mcg_pkg::res_t want;
        if (!aresetn) begin
            cells_due.delete();
            cur_day = '0;
            next_col = '0;
            cur_len = '0;
            cur_start = '0;
            errors <= 0;
            pending <= 0;
            cells_checked <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (cells_due.size() == 0) begin
                    if (errors < REPORT_MAX)
                        $display("%0t: unexpected cell transfer, day %0d col %0d last %0d",
                                 $time, m_data.day_number, m_data.weekday_column,
                                 m_data.last);
                    errors <= errors + 1;
                end else begin
                    want = cells_due.pop_front();
                    cells_checked <= cells_checked + 1;
                    if (m_data.day_number !== want.day_number
                        || m_data.weekday_column !== want.weekday_column
                        || m_data.row_end !== want.row_end
                        || m_data.first_offset !== want.first_offset
                        || m_data.bad_request !== want.bad_request
                        || m_data.last !== want.last) begin
                        if (errors < REPORT_MAX) begin
                            $display("%0t: cell mismatch: exp day %0d col %0d row_end %b off %0d bad %b last %b",
                                     $time, want.day_number, want.weekday_column,
                                     want.row_end, want.first_offset, want.bad_request,
                                     want.last);
                            $display("%0t:                got day %0d col %0d row_end %b off %0d bad %b last %b",
                                     $time, m_data.day_number, m_data.weekday_column,
                                     m_data.row_end, m_data.first_offset,
                                     m_data.bad_request, m_data.last);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                add_month_cells(s_data);
            pending <= cells_due.size();
        end
    end

endmodule

// File: sim/tb_top.sv
// Top of the month calendar grid testbench: clock, reset, request stimulus,
// randomized back-pressure, watchdog and verdict.
// Depends on rtl/mcg_pkg.sv, rtl/month_calendar_grid_generator_core.sv, sim/mcg_checker.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int YEAR_BITS = mcg_pkg::YEAR_W;
    localparam int MONTH_BITS = mcg_pkg::MONTH_W;
    localparam int RANDOM_ITEMS = 207;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    mcg_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    mcg_pkg::res_t m_data;

    int errors;
    int pending;
    int cells_checked;
    int requests_sent;
    int bad_sent;
    int stall_cycles;
    bit steady;

    month_calendar_grid_generator_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mcg_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .errors        (errors),
        .pending       (pending),
        .cells_checked (cells_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one; none at all in steady stretches
    function automatic int unsigned pause_len(input bit no_gaps);
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input int unsigned yr, input int unsigned mo);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data <= '{year: YEAR_BITS'(yr), month: MONTH_BITS'(mo)};
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (mo < 1 || mo > 12)
            bad_sent++;
        gap = pause_len(steady);
        if (gap != 0) begin
            s_valid <= 1'b0;
            s_data <= mcg_pkg::req_t'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // result side back-pressure
    initial begin
        int unsigned gap;
        m_ready <= 1'b0;
        forever begin
            gap = pause_len(steady);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d cells outstanding",
                         STALL_LIMIT, pending);
                $display("** month_calendar_grid_generator_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int unsigned r;
        int unsigned yr;
        int unsigned mo;
        requests_sent = 0;
        bad_sent = 0;
        steady = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes of both fields, leap-year corners, bad months, every month
        send_request(1, 1);
        send_request(9999, 12);
        send_request(0, 1);
        send_request(0, 2);
        send_request(16383, 15);
        send_request(16383, 3);
        send_request(2000, 2);
        send_request(1900, 2);
        send_request(2024, 2);
        send_request(2023, 2);
        send_request(400, 2);
        send_request(100, 2);
        send_request(0, 0);
        send_request(5000, 13);
        send_request(777, 14);
        for (int m = 4; m <= 11; m++)
            send_request(2021, m);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = ((i / 40) % 3 == 1);
            r = $urandom_range(0, 99);
            mo = $urandom_range(1, 12);
            if (r < 72) begin
                yr = $urandom_range(1, 9999);
            end else if (r < 82) begin
                yr = $urandom_range(0, 16383);
            end else if (r < 92) begin
                // century years stress the leap-year rule
                yr = 100 * $urandom_range(0, 163);
                mo = 2;
            end else begin
                yr = $urandom_range(0, 16383);
                mo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
            end
            send_request(yr, mo);
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        // let the checker count the cells of the final transfer
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests (%0d with a bad month) and %0d checked cells.",
                 requests_sent, bad_sent, cells_checked);
        $display("Mismatches or stray cells: %0d", errors);
        if (errors == 0 && pending == 0) begin
            $display("** month_calendar_grid_generator_core: PASSED **");
        end else begin
            $display("** month_calendar_grid_generator_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mcg_pkg.sv
rtl/mcg_front.sv
rtl/mcg_queue.sv
rtl/mcg_back.sv
rtl/month_calendar_grid_generator_core.sv
sim/mcg_checker.sv
sim/tb_top.sv
